FILE: src/hpm_pkg.sv
`default_nettype none
package hpm_pkg;
    localparam logic [15:0] QUIET_NAN       = 16'h7e00;
    localparam logic [15:0] INF_BITS        = 16'h7c00;
    localparam logic [15:0] SMALLEST_NORMAL = 16'h0400;
    localparam int          EXP_MAX         = 30;
    localparam int          EXP_BIAS        = 15;
endpackage
`default_nettype wire

FILE: src/hpm_shift_add.sv
`default_nettype none
// Shift-and-add multiplier step: adds the multiplicand when the current
// multiplier bit is set.
module hpm_shift_add (
    input  wire logic [21:0] i_acc,
    input  wire logic [10:0] i_mcand,
    input  wire logic [3:0]  i_bit_idx,
    input  wire logic        i_bit,
    output logic      [21:0] o_acc
);
    import hpm_pkg::*;
    logic [21:0] w_add;

    // Shift the multiplicand to the bit weight and accumulate.
    always_comb begin
        w_add = {11'd0, i_mcand} << i_bit_idx;
        o_acc = i_bit ? (i_acc + w_add) : i_acc;
    end
endmodule
`default_nettype wire

FILE: src/half_precision_multiplier.sv
`default_nettype none
// Channel   Direction  Signals
// input     in         i_valid, o_ready, i_operand_a, i_operand_b
// output    out        o_valid, i_ready, o_product
//
// Each item is loaded; each subnormal significand is normalized one place
// per leading zero; the shared shift-add unit forms the significand product
// one multiplier bit at a time; the result is rounded and packed. Special
// operands skip to the result at once, in the cycle after the transfer.
// Reset is synchronous and active low and returns the sequencer to idle.
// The result waits in an output register until it is taken; a stalled output
// holds the block busy, and ready returns the cycle after the output transfer.
module half_precision_multiplier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_operand_a,
    input  wire logic [15:0] i_operand_b,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [15:0] o_product
);
    import hpm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_NORM, S_MUL, S_ROUND, S_PACK, S_OUT} t_state;

    t_state        r_state;
    logic [13:0]   r_sa, r_sb;
    logic signed [7:0] r_exp;
    logic [21:0]   r_acc;
    logic [3:0]    r_cnt;
    logic [15:0]   r_hi;
    logic [15:0]   r_lo;
    logic          r_rs;
    logic [15:0]   r_prod;
    logic          r_valid;

    logic [21:0]   w_acc;
    logic          w_sa_ok, w_sb_ok;

    hpm_shift_add u_step (
        .i_acc     (r_acc),
        .i_mcand   (r_sa[13:3]),
        .i_bit_idx (r_cnt),
        .i_bit     (r_sb[4'd3 + r_cnt]),
        .o_acc     (w_acc)
    );

    assign w_sa_ok = r_sa[13];
    assign w_sb_ok = r_sb[13];
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_product = r_prod;

    // Sequencer: decode, normalize, multiply, round, pack, then hold the result; specials skip to output.
    always_ff @(posedge i_clk) begin
        logic [4:0]  ea, eb;
        logic [9:0]  fa, fb;
        logic        sa, sb;
        logic [27:0] pr;
        logic [31:0] full;
        logic [31:0] sh;
        logic [16:0] hi2;
        logic [11:0] h;
        logic signed [8:0] e;
        logic [5:0]  n;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        ea = i_operand_a[14:10]; eb = i_operand_b[14:10];
                        fa = i_operand_a[9:0];   fb = i_operand_b[9:0];
                        sa = i_operand_a[15];    sb = i_operand_b[15];
                        r_rs  <= sa ^ sb;
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                        if (ea == 5'd31 && fa != 10'd0) r_prod <= i_operand_a;
                        else if (eb == 5'd31 && fb != 10'd0) r_prod <= i_operand_b;
                        else if (ea == 5'd0 && fa == 10'd0)
                            r_prod <= (eb == 5'd31) ? QUIET_NAN : i_operand_a;
                        else if (eb == 5'd0 && fb == 10'd0)
                            r_prod <= (ea == 5'd31) ? QUIET_NAN : i_operand_b;
                        else if (ea == 5'd31 || eb == 5'd31)
                            r_prod <= {sa ^ sb, INF_BITS[14:0]};
                        else begin
                            r_valid <= 1'b0;
                            r_state <= S_NORM;
                            r_sa  <= {(ea != 5'd0), fa, 3'd0};
                            r_sb  <= {(eb != 5'd0), fb, 3'd0};
                            r_exp <= 8'(signed'({3'd0, ea}) + signed'({3'd0, eb})
                                     - 8'sd15 + ((ea == 5'd0) ? 8'sd1 : 8'sd0)
                                     + ((eb == 5'd0) ? 8'sd1 : 8'sd0));
                        end
                    end
                end
                // Normalize subnormal significands one place per cycle.
                S_NORM: begin
                    if (!w_sa_ok) begin
                        r_sa <= r_sa << 1; r_exp <= r_exp - 8'sd1;
                    end else if (!w_sb_ok) begin
                        r_sb <= r_sb << 1; r_exp <= r_exp - 8'sd1;
                    end else begin
                        r_acc <= '0; r_cnt <= '0; r_state <= S_MUL;
                    end
                end
                // One multiplier bit per cycle; low 3 bits of sig_b are zero.
                S_MUL: begin
                    r_acc <= w_acc;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd10) r_state <= S_ROUND;
                end
                // First rounding on the half-ulp bit.
                S_ROUND: begin
                    pr = {r_acc, 6'd0};
                    e  = 9'(r_exp);
                    if (pr[27]) begin pr = pr >> 1; e = e + 9'sd1; end
                    h = {1'b0, pr[26:16]};
                    if (pr[15]) begin
                        h = h + 12'd1;
                        if (h[11]) begin h = h >> 1; e = e + 9'sd1; end
                    end
                    r_hi  <= {4'd0, h};
                    r_lo  <= pr[15:0];
                    r_exp <= 8'(e);
                    r_state <= S_PACK;
                end
                // Pack normal, infinity or subnormal with second rounding.
                S_PACK: begin
                    if (r_exp > 8'sd30) r_prod <= {r_rs, INF_BITS[14:0]};
                    else if (r_exp > 8'sd0)
                        r_prod <= {r_rs, r_exp[4:0], r_hi[9:0]};
                    else begin
                        full = {r_hi, r_lo};
                        e = 9'sd1 - 9'(r_exp);
                        n = (e >= 9'sd32) ? 6'd32 : e[5:0];
                        sh = n[5] ? 32'd0 : (full >> n[4:0]);
                        hi2 = {1'b0, sh[31:16]};
                        if (sh[15]) hi2 = hi2 + 17'd1;
                        if (sh[15] && hi2[10]) r_prod <= {r_rs, SMALLEST_NORMAL[14:0]};
                        else r_prod <= {r_rs, 5'd0, hi2[9:0]};
                    end
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The block never accepts while a result is pending.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while result pending");
    // Result valid implies the output state.
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT)) else $error("valid outside output state");
    // Multiply counter stays within the significand width.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= 4'd10)) else $error("counter overrun");
endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import hpm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_operand_a;
    logic [15:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_product;

    half_precision_multiplier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .o_valid(o_valid), .i_ready(i_ready), .o_product(o_product)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    logic [31:0] pending_ops[$];
    logic [15:0] expected_products[$];
    int          error_count = 0;
    bit          stimulus_done = 0;
    longint      cycle_count = 0;

    // Shift a significand so its unit bit sits at position 13 and adjust the exponent.
    function automatic logic [31:0] align_significand(input logic [4:0] e, input logic [9:0] f,
                                                      inout int exp_val);
        logic [31:0] s;
        s = {19'd0, f, 3'd0};
        if (e != 5'd0) begin
            return s | 32'h2000;
        end
        exp_val = exp_val + 1;
        for (int i = 0; i < 14; i++) begin
            if (s[13]) break;
            s = s << 1;
            exp_val = exp_val - 1;
        end
        return s;
    endfunction

    // Expected binary16 product of two operands.
    function automatic logic [15:0] predict_product(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] rs;
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        int          r_exp;
        int          n;
        logic [31:0] sig_a, sig_b, prod, hi, lo;
        rs = {a[15] ^ b[15], 15'd0};
        a_nan = (a[14:10] == 5'h1f) && (a[9:0] != 0);
        b_nan = (b[14:10] == 5'h1f) && (b[9:0] != 0);
        a_inf = (a[14:10] == 5'h1f) && (a[9:0] == 0);
        b_inf = (b[14:10] == 5'h1f) && (b[9:0] == 0);
        a_zero = (a[14:0] == 0);
        b_zero = (b[14:0] == 0);
        if (a_nan) return a;
        if (b_nan) return b;
        if (a_zero) return b_inf ? QUIET_NAN : a;
        if (b_zero) return a_inf ? QUIET_NAN : b;
        if (a_inf || b_inf) return rs | INF_BITS;
        r_exp = int'(a[14:10]) + int'(b[14:10]) - EXP_BIAS;
        sig_a = align_significand(a[14:10], a[9:0], r_exp);
        sig_b = align_significand(b[14:10], b[9:0], r_exp);
        prod = sig_a * sig_b;
        if (prod[27]) begin
            prod = prod >> 1;
            r_exp = r_exp + 1;
        end
        hi = prod >> 16;
        lo = prod & 32'hffff;
        if (lo[15]) begin
            hi = hi + 1;
            if (hi[11]) begin
                hi = hi >> 1;
                r_exp = r_exp + 1;
            end
        end
        if (r_exp > EXP_MAX) return rs | INF_BITS;
        if (r_exp > 0) return rs | {1'b0, 5'(r_exp), hi[9:0]};
        // Subnormal result: shift the once-rounded register and round again.
        prod = {hi[15:0], lo[15:0]};
        n = 1 - r_exp;
        prod = (n >= 32) ? 32'd0 : (prod >> n);
        hi = prod >> 16;
        lo = prod & 32'hffff;
        if (lo[15]) begin
            hi = hi + 1;
            if (hi[10]) return rs | SMALLEST_NORMAL;
        end
        return rs | {6'd0, hi[9:0]};
    endfunction

    // Random operand biased toward special encodings and small or large exponents.
    function automatic logic [15:0] random_operand();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 9))
            0: v[14:10] = 5'h00;
            1: v[14:10] = 5'h1f;
            2: v[14:0] = 15'd0;
            3: v[14:10] = 5'($urandom_range(0, 4));
            4: v[14:10] = 5'($urandom_range(26, 30));
            default: ;
        endcase
        return v;
    endfunction

    // Fill the queue with directed and random operand pairs.
    initial begin
        logic [15:0] edge_vals[12];
        edge_vals = '{16'h0000, 16'h8000, 16'h7c00, 16'hfc00, 16'h7e00, 16'hfd55,
                      16'h0001, 16'h83ff, 16'h0400, 16'h7bff, 16'h3c00, 16'hbc01};
        for (int i = 0; i < 12; i++) begin
            pending_ops.push_back({edge_vals[i], edge_vals[(i * 5 + 3) % 12]});
        end
        pending_ops.push_back({16'h7c00, 16'h0000});
        pending_ops.push_back({16'h0000, 16'hfc00});
        pending_ops.push_back({16'h7e01, 16'h7d00});
        pending_ops.push_back({16'h8000, 16'h0000});
        pending_ops.push_back({16'h7bff, 16'h7bff});
        pending_ops.push_back({16'h0001, 16'h0001});
        pending_ops.push_back({16'h0200, 16'h3c00});
        pending_ops.push_back({16'h03ff, 16'h3c01});
        pending_ops.push_back({16'h0400, 16'h3bff});
        pending_ops.push_back({16'h5bff, 16'h5c00});
        pending_ops.push_back({16'hffff, 16'hffff});
        for (int i = 0; i < 1000; i++) begin
            pending_ops.push_back({random_operand(), random_operand()});
        end
    end

    // Hold reset low at the start, then release it.
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: presents one pair at a time after a random gap.
    int in_gap = 0;
    initial begin
        i_valid = 1'b0;
        i_operand_a = '0;
        i_operand_b = '0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_products.push_back(predict_product(i_operand_a, i_operand_b));
            end
            if (!i_valid || o_ready) begin
                if (in_gap > 0) begin
                    i_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end else if (pending_ops.size() > 0) begin
                    logic [31:0] op;
                    op = pending_ops.pop_front();
                    i_valid <= 1'b1;
                    i_operand_a <= op[31:16];
                    i_operand_b <= op[15:0];
                    in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                end else begin
                    i_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Monitor: random backpressure and comparison of each transfer.
    int out_gap = 0;
    initial i_ready = 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_products.size() == 0) begin
                    $error("product: unexpected transfer, actual %h", o_product);
                    error_count++;
                end else begin
                    logic [15:0] exp_p;
                    exp_p = expected_products.pop_front();
                    if (exp_p !== o_product) begin
                        $error("product: expected %h actual %h", exp_p, o_product);
                        error_count++;
                    end
                end
                out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                i_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // End of run and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 500000) begin
            $display("tb: errors");
            $finish;
        end
    end
    initial begin
        wait (stimulus_done && expected_products.size() == 0);
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_products.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

FILE: files.f
src/hpm_pkg.sv
src/hpm_shift_add.sv
src/half_precision_multiplier.sv
bench/tb.sv
